// ===== hw/rtl/gf13_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gf13_pkg;

    localparam int FIELD_BITS = 13;
    localparam int DIVSTEPS   = 2 * FIELD_BITS - 1;

    localparam logic [15:0] FIELD_POLY = 16'h201b;
    localparam logic [13:0] R_SEED     = 14'h2000;
    localparam logic signed [5:0] DELTA_SEED = 6'sd1;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_SQR = 2'd1,
        OP_INV = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [12:0]        a;
        logic [12:0]        b;
        logic [15:0]        f;
        logic [15:0]        g;
        logic [13:0]        r;
        logic [13:0]        v;
        logic signed [5:0]  delta;
    } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gf13_divstep_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gf13_divstep_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire gf13_pkg::stage_t in_stage,
    output logic                 out_valid,
    output gf13_pkg::stage_t     out_stage
);

    logic             valid_reg;
    gf13_pkg::stage_t stage_reg;
    gf13_pkg::stage_t stage_next;

    logic        g0;
    logic        swap;
    logic [15:0] g1;
    logic [13:0] v1;

    always_comb
    begin
        g0   = in_stage.g[13];
        swap = g0 && !in_stage.delta[5] && (in_stage.delta != 6'sd0);
        g1   = g0 ? (in_stage.g ^ in_stage.f) : in_stage.g;
        v1   = swap ? in_stage.r : in_stage.v;

        stage_next       = in_stage;
        stage_next.delta = swap ? (6'sd1 - in_stage.delta) : (in_stage.delta + 6'sd1);
        stage_next.r     = g0 ? (in_stage.r ^ in_stage.v) : in_stage.r;
        stage_next.f     = swap ? in_stage.g : in_stage.f;
        stage_next.g     = {g1[14:0], 1'b0};
        stage_next.v     = {1'b0, v1[13:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gf13_mul_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gf13_mul_cell
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire gf13_pkg::stage_t in_stage,
    output logic                  out_valid,
    output logic [12:0]           out_result
);

    logic        valid_reg;
    logic [12:0] result_reg;
    logic [12:0] result_next;

    logic [12:0] x;
    logic [12:0] y;
    logic [24:0] prod;
    logic [15:0] hi;
    logic [15:0] t;
    logic [12:0] hi2;
    logic [12:0] reduced;

    always_comb
    begin
        x = in_stage.a;
        unique case (in_stage.op)
            gf13_pkg::OP_MUL: y = in_stage.b;
            gf13_pkg::OP_SQR: y = in_stage.a;
            gf13_pkg::OP_INV: y = in_stage.v[12:0];
            gf13_pkg::OP_DIV: y = in_stage.v[12:0];
            default:          y = in_stage.v[12:0];
        endcase

        prod = 25'd0;
        for (int i = 0; i < 13; i++)
        begin
            if (y[i])
            begin
                prod = prod ^ ({12'd0, x} << i);
            end
        end

        hi      = {4'd0, prod[24:13]};
        t       = {3'd0, prod[12:0]} ^ hi ^ (hi << 1) ^ (hi << 3) ^ (hi << 4);
        hi2     = {10'd0, t[15:13]};
        reduced = t[12:0] ^ hi2 ^ (hi2 << 1) ^ (hi2 << 3) ^ (hi2 << 4);

        if (in_stage.op == gf13_pkg::OP_INV)
        begin
            result_next = in_stage.v[12:0];
        end
        else
        begin
            result_next = reduced;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gf2_13_field_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// GF(2^13) arithmetic unit, polynomial x^13 + x^4 + x^3 + x + 1.
// Command channel: a word (operation, operand_a, operand_b) is taken at
// every rising edge with start high and busy low. busy is held low, so a
// new word may be given in every cycle.
// Operations: multiply a*b, square a, inverse of b, divide a by b. The
// inverse and quotient of a zero divisor are zero.
// Result channel: done and result are registered in the last of a chain
// of stages (an input register, 25 division-step cells in a row, then one
// multiply cell). Every operation takes the same path, so results leave
// in the order words arrived.
// Throughput: one word per cycle; the input register, the divstep chain
// and the multiply cell hold up to 27 words in flight.
// Reset (rst_n low) clears all valid flags; words in flight are dropped
// and done stays low until new words reach the end of the chain.
// The receiver cannot stall: each result is present for one cycle only.
module gf2_13_field_alu_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [12:0] operand_a,
    input  wire logic [12:0] operand_b,
    output logic             done,
    output logic [12:0]      result
);

    localparam int LATENCY = gf13_pkg::DIVSTEPS + 2;

    logic             chain_valid [0:gf13_pkg::DIVSTEPS];
    gf13_pkg::stage_t chain_stage [0:gf13_pkg::DIVSTEPS];

    logic             seed_valid_reg;
    gf13_pkg::stage_t seed_reg;
    gf13_pkg::stage_t seed_next;

    assign busy = 1'b0;

    always_comb
    begin
        seed_next.op    = gf13_pkg::op_t'(operation);
        seed_next.a     = operand_a;
        seed_next.b     = operand_b;
        seed_next.f     = gf13_pkg::FIELD_POLY;
        seed_next.g     = {2'b00, operand_b, 1'b0};
        seed_next.r     = gf13_pkg::R_SEED;
        seed_next.v     = 14'd0;
        seed_next.delta = gf13_pkg::DELTA_SEED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_valid_reg <= 1'b0;
        end
        else
        begin
            seed_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
    end

    assign chain_valid[0] = seed_valid_reg;
    assign chain_stage[0] = seed_reg;

    for (genvar i = 0; i < gf13_pkg::DIVSTEPS; i++)
    begin : g_cell
        gf13_divstep_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_stage  (chain_stage[i]),
            .out_valid (chain_valid[i + 1]),
            .out_stage (chain_stage[i + 1])
        );
    end

    gf13_mul_cell u_mul
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[gf13_pkg::DIVSTEPS]),
        .in_stage   (chain_stage[gf13_pkg::DIVSTEPS]),
        .out_valid  (done),
        .out_result (result)
    );

`ifndef SYNTHESIS
    a_done_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("done without a word taken earlier");

    a_start_gives_done : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("word taken but no result");

    a_zero_divisor : assert property (@(posedge clk) disable iff (!rst_n)
        (start && operand_b == 13'd0
            && (operation == gf13_pkg::OP_INV || operation == gf13_pkg::OP_DIV))
        |-> ##LATENCY (result == 13'd0))
        else $error("zero divisor gave non-zero result");
`endif

endmodule

`default_nettype wire

// ===== dv/gf2_13_field_alu_core_tb.sv =====
`timescale 1ns / 1ps

module gf2_13_field_alu_core_tb;

    class field_scoreboard;
        logic [12:0] awaited_results[$];
        int          errors = 0;

        function logic [12:0] field_product(logic [12:0] x, logic [12:0] y);
            logic [25:0] acc;
            acc = '0;
            for (int i = 0; i < gf13_pkg::FIELD_BITS; i++)
            begin
                if (y[i])
                    acc ^= {13'b0, x} << i;
            end
            for (int i = 2 * gf13_pkg::FIELD_BITS - 2; i >= gf13_pkg::FIELD_BITS; i--)
            begin
                if (acc[i])
                    acc ^= {10'b0, gf13_pkg::FIELD_POLY} << (i - gf13_pkg::FIELD_BITS);
            end
            return acc[12:0];
        endfunction

        function logic [12:0] field_inverse(logic [12:0] x);
            logic [31:0] f, g, r, v, fg, vr;
            logic        g0, swap;
            int          delta;
            f = {16'b0, gf13_pkg::FIELD_POLY};
            g = {19'b0, x} << 1;
            r = {18'b0, gf13_pkg::R_SEED};
            v = '0;
            delta = 1;
            for (int i = 0; i < gf13_pkg::DIVSTEPS; i++)
            begin
                g0 = g[gf13_pkg::FIELD_BITS];
                swap = (delta > 0) && g0;
                fg = f ^ g;
                vr = v ^ r;
                delta = swap ? 1 - delta : delta + 1;
                if (g0)
                begin
                    g ^= f;
                    r ^= v;
                end
                if (swap)
                begin
                    f ^= fg;
                    v ^= vr;
                end
                g = (g << 1) & 32'hffff;
                v = v >> 1;
            end
            return v[12:0];
        endfunction

        function void note_word(gf13_pkg::op_t op, logic [12:0] a, logic [12:0] b);
            logic [12:0] value;
            case (op)
                gf13_pkg::OP_MUL: value = field_product(a, b);
                gf13_pkg::OP_SQR: value = field_product(a, a);
                gf13_pkg::OP_INV: value = field_inverse(b);
                default:          value = field_product(a, field_inverse(b));
            endcase
            awaited_results.push_back(value);
        endfunction

        function void check_result(logic [12:0] got);
            logic [12:0] want;
            if (awaited_results.size() == 0)
            begin
                if (errors < 10)
                    $display("result %h arrived with no word outstanding", got);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got !== want)
            begin
                if (errors < 10)
                    $display("result mismatch: expected %h, got %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  operation = gf13_pkg::OP_MUL;
    logic [12:0] operand_a = '0;
    logic [12:0] operand_b = '0;
    logic        busy;
    logic        done;
    logic [12:0] result;

    field_scoreboard field_results;
    int              drain_cycles;

    gf2_13_field_alu_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .result    (result)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (start && !busy)
            field_results.note_word(gf13_pkg::op_t'(operation), operand_a, operand_b);
        if (done)
            field_results.check_result(result);
    end

    // hold start high across back-to-back words
    task automatic send_word(gf13_pkg::op_t op, logic [12:0] a, logic [12:0] b,
                             int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_random_word(int idle_pct);
        gf13_pkg::op_t op;
        logic [12:0]   a;
        logic [12:0]   b;
        op = gf13_pkg::op_t'(2'($urandom_range(3)));
        a = 13'($urandom_range(8191));
        b = 13'($urandom_range(8191));
        case ($urandom_range(15))
            0:       b = '0;
            1:       b = 13'h0001;
            2:       b = a;
            3:       a = '0;
            4:       a = 13'h1fff;
            default: ;
        endcase
        send_word(op, a, b, idle_pct);
    endtask

    initial
    begin
        field_results = new;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(gf13_pkg::OP_MUL, 13'h0000, 13'h0000, 25);
        send_word(gf13_pkg::OP_MUL, 13'h1fff, 13'h1fff, 25);
        send_word(gf13_pkg::OP_MUL, 13'h0001, 13'h1abc, 25);
        send_word(gf13_pkg::OP_MUL, 13'h1000, 13'h1000, 25);
        send_word(gf13_pkg::OP_MUL, 13'h1555, 13'h0aaa, 25);
        send_word(gf13_pkg::OP_SQR, 13'h0000, 13'h1fff, 25);
        send_word(gf13_pkg::OP_SQR, 13'h1fff, 13'h0000, 25);
        send_word(gf13_pkg::OP_SQR, 13'h1000, 13'h1fff, 25);
        send_word(gf13_pkg::OP_SQR, 13'h0001, 13'h1555, 25);
        send_word(gf13_pkg::OP_INV, 13'h1fff, 13'h0000, 25);
        send_word(gf13_pkg::OP_INV, 13'h0000, 13'h0001, 25);
        send_word(gf13_pkg::OP_INV, 13'h1555, 13'h1fff, 25);
        send_word(gf13_pkg::OP_INV, 13'h0000, 13'h1000, 25);
        send_word(gf13_pkg::OP_INV, 13'h0aaa, 13'h0002, 25);
        send_word(gf13_pkg::OP_DIV, 13'h1fff, 13'h0000, 25);
        send_word(gf13_pkg::OP_DIV, 13'h0000, 13'h1fff, 25);
        send_word(gf13_pkg::OP_DIV, 13'h0001, 13'h0001, 25);
        send_word(gf13_pkg::OP_DIV, 13'h1abc, 13'h1abc, 25);
        send_word(gf13_pkg::OP_DIV, 13'h1fff, 13'h1000, 25);
        send_word(gf13_pkg::OP_DIV, 13'h0aaa, 13'h1555, 25);

        repeat (450) send_random_word(25);
        repeat (450) send_random_word(77);
        repeat (450) send_random_word(0);
        start <= 1'b0;

        drain_cycles = 0;
        while (field_results.awaited_results.size() != 0 && drain_cycles < 200)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (30) @(posedge clk);
        if (field_results.awaited_results.size() != 0)
        begin
            $display("%0d results never arrived", field_results.awaited_results.size());
            field_results.errors++;
        end

        if (field_results.errors == 0)
            $display("gf2_13_field_alu_core_tb: PASS");
        else
            $display("gf2_13_field_alu_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        #200000;
        $display("gf2_13_field_alu_core_tb: FAIL");
        $finish;
    end

endmodule

// ===== gf2_13_field_alu_core.f =====
hw/rtl/gf13_pkg.sv
hw/rtl/gf13_divstep_cell.sv
hw/rtl/gf13_mul_cell.sv
hw/rtl/gf2_13_field_alu.sv
dv/gf2_13_field_alu_core_tb.sv
